// ===== rtl/ffsa_pkg.sv =====
// Package with the shared types and codes of the first-fit segment allocator.
package ffsa_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_POS,
    S_A_SHIFT,
    S_A_UPD,
    S_A_UPD2,
    S_F_REM,
    S_D_SCAN,
    S_D_POS,
    S_D_SHIFT,
    S_D_REM,
    S_C_STEP,
    S_C_MERGE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_COAL  = 2'd2
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_NOID  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [15:0] SIZE_RESET = 16'hFFFF;
  localparam logic [15:0] SIZE_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [16:0] sum;
    logic [15:0] diff;
    logic        ge;
    logic        eq;
  } alu_res_t;

endpackage

// ===== rtl/ffsa_alu.sv =====
// Shared add, subtract and compare unit used by the allocator sequencer.
module ffsa_alu (
  input  logic [15:0]        opa,
  input  logic [15:0]        opb,
  output ffsa_pkg::alu_res_t res
);
  import ffsa_pkg::*;

  always_comb begin
    res.sum  = {1'b0, opa} + {1'b0, opb};
    res.diff = opa - opb;
    res.ge   = (opa >= opb);
    res.eq   = (opa == opb);
  end

endmodule

// ===== rtl/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator: sequencer, tables and stream ports.
// Each request is handled alone by a sequencer that walks the sorted free and
// allocation tables one entry per cycle through one shared add/compare unit.
// An allocate scans the free table for the first fit, finds the insert
// position in the allocation table, shifts the later entries up, inserts the
// new entry and shrinks the fitting free segment, plus a free-table compaction
// pass on an exact fit; a free takes a similar scan of the allocation table, a
// sorted insert into the free table and a compaction of the allocation table;
// a coalesce walks the free table once with a compaction pass per merge. The
// input is ready only while the sequencer is idle; one result register holds
// the answer until it is taken. Writing total_size resets the free table to
// one segment at address zero and leaves the allocation table as it is.
module first_fit_segment_allocator #(
  parameter int FREE_ENTRIES  = 16,
  parameter int ALLOC_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // total_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // proc_id [7:0], block_size [23:8]
  input  logic [1:0]  in_tuser,     // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // address
  output logic [1:0]  out_tuser     // status
);
  import ffsa_pkg::*;

  localparam int FI_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int AI_W = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
  localparam int FC_W = $clog2(FREE_ENTRIES + 1);
  localparam int AC_W = $clog2(ALLOC_ENTRIES + 1);
  localparam int IW   = (FC_W > AC_W) ? FC_W : AC_W;

  state_t state_r, state_nxt;

  logic [15:0] fstart_r [FREE_ENTRIES];
  logic [15:0] fsize_r  [FREE_ENTRIES];
  logic [15:0] fstart_nxt [FREE_ENTRIES];
  logic [15:0] fsize_nxt  [FREE_ENTRIES];
  logic [7:0]  aown_r   [ALLOC_ENTRIES];
  logic [15:0] astart_r [ALLOC_ENTRIES];
  logic [15:0] asize_r  [ALLOC_ENTRIES];
  logic [7:0]  aown_nxt   [ALLOC_ENTRIES];
  logic [15:0] astart_nxt [ALLOC_ENTRIES];
  logic [15:0] asize_nxt  [ALLOC_ENTRIES];

  logic [FC_W-1:0] fc_r, fc_nxt;
  logic [AC_W-1:0] ac_r, ac_nxt;
  logic [IW-1:0]   idx_r, idx_nxt, sel_r, sel_nxt, pos_r, pos_nxt;
  logic [15:0]     start_r, start_nxt, size_r, size_nxt;
  logic [7:0]      owner_r, owner_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [15:0]     addr_r, addr_nxt;
  logic            ov_r, ov_nxt;
  logic [15:0]     od_r, od_nxt;
  logic [1:0]      ou_r, ou_nxt;

  logic [IW-1:0]   idx_p1, idx_m1;
  logic [FI_W-1:0] fi, fi1, fim1, fsel, fpos;
  logic [AI_W-1:0] ai, ai1, aim1, apos;
  logic            f_more, f_more2, a_more, a_more2, a_full, f_full, accept;
  logic            end_eq, slot_free;
  logic [15:0]     alu_a, alu_b, sat_sum;
  alu_res_t        alu;

  assign idx_p1  = idx_r + 1'b1;
  assign idx_m1  = idx_r - 1'b1;
  assign fi      = idx_r[FI_W-1:0];
  assign fi1     = idx_p1[FI_W-1:0];
  assign fim1    = idx_m1[FI_W-1:0];
  assign fsel    = sel_r[FI_W-1:0];
  assign fpos    = pos_r[FI_W-1:0];
  assign ai      = idx_r[AI_W-1:0];
  assign ai1     = idx_p1[AI_W-1:0];
  assign aim1    = idx_m1[AI_W-1:0];
  assign apos    = pos_r[AI_W-1:0];
  assign f_more  = idx_r < IW'(fc_r);
  assign f_more2 = idx_p1 < IW'(fc_r);
  assign a_more  = idx_r < IW'(ac_r);
  assign a_more2 = idx_p1 < IW'(ac_r);
  assign a_full  = ac_r >= AC_W'(ALLOC_ENTRIES);
  assign f_full  = fc_r >= FC_W'(FREE_ENTRIES);
  assign accept  = in_tvalid && in_tready;
  assign end_eq  = (alu.sum == {1'b0, fstart_r[fi1]});
  assign sat_sum = alu.sum[16] ? SIZE_MAX : alu.sum[15:0];
  assign slot_free = !ov_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_A_SCAN:  begin alu_a = fsize_r[fi];      alu_b = size_r;          end
      S_A_POS:   begin alu_a = start_r;          alu_b = astart_r[ai];    end
      S_A_UPD:   begin alu_a = fsize_r[fsel];    alu_b = size_r;          end
      S_A_UPD2:  begin alu_a = fstart_r[fsel];   alu_b = size_r;          end
      S_D_SCAN:  begin alu_a = {8'h00, aown_r[ai]}; alu_b = {8'h00, owner_r}; end
      S_D_POS:   begin alu_a = start_r;          alu_b = fstart_r[fi];    end
      S_C_STEP:  begin alu_a = fstart_r[fi];     alu_b = fsize_r[fi];     end
      S_C_MERGE: begin alu_a = fsize_r[fi];      alu_b = fsize_r[fi1];    end
      default:   begin alu_a = '0;               alu_b = '0;              end
    endcase
  end

  ffsa_alu u_alu (
    .opa (alu_a),
    .opb (alu_b),
    .res (alu)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_tuser)
            REQ_ALLOC: state_nxt = (in_tdata[23:8] == 16'd0) ? S_DONE : S_A_SCAN;
            REQ_FREE:  state_nxt = S_D_SCAN;
            REQ_COAL:  state_nxt = S_C_STEP;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_A_SCAN: begin
        if (!f_more) state_nxt = S_DONE;
        else if (alu.ge) state_nxt = a_full ? S_DONE : S_A_POS;
      end
      S_A_POS:   if (!(a_more && alu.ge)) state_nxt = S_A_SHIFT;
      S_A_SHIFT: if (idx_r <= pos_r) state_nxt = S_A_UPD;
      S_A_UPD:   state_nxt = alu.eq ? S_F_REM : S_A_UPD2;
      S_A_UPD2:  state_nxt = S_DONE;
      S_F_REM:   if (!f_more2) state_nxt = (op_r == REQ_COAL) ? S_C_STEP : S_DONE;
      S_D_SCAN: begin
        if (!a_more) state_nxt = S_DONE;
        else if (alu.eq) state_nxt = f_full ? S_DONE : S_D_POS;
      end
      S_D_POS:   if (!(f_more && alu.ge)) state_nxt = S_D_SHIFT;
      S_D_SHIFT: if (idx_r <= pos_r) state_nxt = S_D_REM;
      S_D_REM:   if (!a_more2) state_nxt = S_DONE;
      S_C_STEP: begin
        if (!f_more2) state_nxt = S_DONE;
        else if (end_eq) state_nxt = S_C_MERGE;
      end
      S_C_MERGE: state_nxt = S_F_REM;
      S_DONE:    if (slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fstart_nxt = fstart_r;
    fsize_nxt  = fsize_r;
    aown_nxt   = aown_r;
    astart_nxt = astart_r;
    asize_nxt  = asize_r;
    fc_nxt     = fc_r;
    ac_nxt     = ac_r;
    idx_nxt    = idx_r;
    sel_nxt    = sel_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    size_nxt   = size_r;
    owner_nxt  = owner_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    addr_nxt   = addr_r;
    ov_nxt     = ov_r && !out_tready;
    od_nxt     = od_r;
    ou_nxt     = ou_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt    = '0;
          op_nxt     = in_tuser;
          owner_nxt  = in_tdata[7:0];
          size_nxt   = in_tdata[23:8];
          addr_nxt   = '0;
          status_nxt = ((in_tuser == REQ_ALLOC) && (in_tdata[23:8] == 16'd0)) ?
                       ST_NOFIT : ST_OK;
        end
      end
      S_A_SCAN: begin
        if (!f_more) begin
          status_nxt = ST_NOFIT;
        end else if (alu.ge) begin
          sel_nxt   = idx_r;
          start_nxt = fstart_r[fi];
          if (a_full) status_nxt = ST_FULL;
          else idx_nxt = '0;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      S_A_POS: begin
        if (a_more && alu.ge) begin
          idx_nxt = idx_p1;
        end else begin
          pos_nxt = idx_r;
          idx_nxt = IW'(ac_r);
        end
      end
      S_A_SHIFT: begin
        if (idx_r > pos_r) begin
          aown_nxt[ai]   = aown_r[aim1];
          astart_nxt[ai] = astart_r[aim1];
          asize_nxt[ai]  = asize_r[aim1];
          idx_nxt        = idx_m1;
        end else begin
          aown_nxt[apos]   = owner_r;
          astart_nxt[apos] = start_r;
          asize_nxt[apos]  = size_r;
          ac_nxt           = ac_r + 1'b1;
          addr_nxt         = start_r;
        end
      end
      S_A_UPD: begin
        if (alu.eq) idx_nxt = sel_r;
        else fsize_nxt[fsel] = alu.diff;
      end
      S_A_UPD2: fstart_nxt[fsel] = alu.sum[15:0];
      S_F_REM: begin
        if (f_more2) begin
          fstart_nxt[fi] = fstart_r[fi1];
          fsize_nxt[fi]  = fsize_r[fi1];
          idx_nxt        = idx_p1;
        end else begin
          fc_nxt  = fc_r - 1'b1;
          idx_nxt = sel_r;
        end
      end
      S_D_SCAN: begin
        if (!a_more) begin
          status_nxt = ST_NOID;
        end else if (alu.eq) begin
          sel_nxt   = idx_r;
          start_nxt = astart_r[ai];
          size_nxt  = asize_r[ai];
          if (f_full) status_nxt = ST_FULL;
          else idx_nxt = '0;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      S_D_POS: begin
        if (f_more && alu.ge) begin
          idx_nxt = idx_p1;
        end else begin
          pos_nxt = idx_r;
          idx_nxt = IW'(fc_r);
        end
      end
      S_D_SHIFT: begin
        if (idx_r > pos_r) begin
          fstart_nxt[fi] = fstart_r[fim1];
          fsize_nxt[fi]  = fsize_r[fim1];
          idx_nxt        = idx_m1;
        end else begin
          fstart_nxt[fpos] = start_r;
          fsize_nxt[fpos]  = size_r;
          fc_nxt           = fc_r + 1'b1;
          idx_nxt          = sel_r;
        end
      end
      S_D_REM: begin
        if (a_more2) begin
          aown_nxt[ai]   = aown_r[ai1];
          astart_nxt[ai] = astart_r[ai1];
          asize_nxt[ai]  = asize_r[ai1];
          idx_nxt        = idx_p1;
        end else begin
          ac_nxt = ac_r - 1'b1;
        end
      end
      S_C_STEP: if (f_more2 && !end_eq) idx_nxt = idx_p1;
      S_C_MERGE: begin
        fsize_nxt[fi] = sat_sum;
        sel_nxt       = idx_r;
        idx_nxt       = idx_p1;
      end
      S_DONE: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          od_nxt = addr_r;
          ou_nxt = status_r;
        end
      end
      default: ;
    endcase
    if (cfg_we) begin
      fstart_nxt[0] = '0;
      fsize_nxt[0]  = cfg_wdata;
      fc_nxt        = FC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    aown_r    <= aown_nxt;
    astart_r  <= astart_nxt;
    asize_r   <= asize_nxt;
    idx_r     <= idx_nxt;
    sel_r     <= sel_nxt;
    pos_r     <= pos_nxt;
    start_r   <= start_nxt;
    size_r    <= size_nxt;
    owner_r   <= owner_nxt;
    op_r      <= op_nxt;
    status_r  <= status_nxt;
    addr_r    <= addr_nxt;
    od_r      <= od_nxt;
    ou_r      <= ou_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= FC_W'(1);
      ac_r        <= '0;
      ov_r        <= 1'b0;
      fstart_r[0] <= '0;
      fsize_r[0]  <= SIZE_RESET;
    end else begin
      state_r  <= state_nxt;
      fc_r     <= fc_nxt;
      ac_r     <= ac_nxt;
      ov_r     <= ov_nxt;
      fstart_r <= fstart_nxt;
      fsize_r  <= fsize_nxt;
    end
  end

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FC_W'(FREE_ENTRIES))
    else $error("free table count out of range");

  a_ac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ac_r <= AC_W'(ALLOC_ENTRIES))
    else $error("allocation table count out of range");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> (out_tdata == 16'd0))
    else $error("failed request returned a nonzero address");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a request is in progress");

endmodule
